// ===== hw/rtl/sfb_pkg.sv =====
// sfb_pkg: constants, byte position codes and crc helper for the status frame builder
// no dependencies; used by status_frame_builder_crc8_core
package sfb_pkg;

  // fixed frame header bytes
  localparam logic [7:0] HDR_B0 = 8'h8C;
  localparam logic [7:0] HDR_B1 = 8'h01;
  localparam logic [7:0] HDR_B2 = 8'h85;

  // length field is payload count plus this overhead
  localparam logic [7:0] LEN_OVERHEAD = 8'd4;

  // reflected crc-8 polynomial, zero init, no final xor
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
  localparam logic [7:0] CRC_INIT      = 8'h00;

  // byte counter saturation value
  localparam logic [7:0] CNT_MAX = 8'hFF;

  // configuration register indexes
  localparam logic REG_PAYLOAD_COUNT = 1'b0;
  localparam logic REG_FLAG_BYTE     = 1'b1;

  // position of a byte within the bytes released by one payload byte
  localparam logic [2:0] POS_HDR0    = 3'd0;
  localparam logic [2:0] POS_HDR1    = 3'd1;
  localparam logic [2:0] POS_HDR2    = 3'd2;
  localparam logic [2:0] POS_LEN     = 3'd3;
  localparam logic [2:0] POS_FLAG    = 3'd4;
  localparam logic [2:0] POS_PAYLOAD = 3'd5;
  localparam logic [2:0] POS_CRC     = 3'd6;

  // one byte step of the reflected crc, lsb first
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/status_frame_builder_crc8_core.sv =====
// The first byte released by a payload byte passes the job register, then the output register.
// Throughput: one frame byte per cycle while out_ready_i is high, set by the single output byte
// register; a payload byte gives 1 byte, 6 when it opens a frame, one more when it closes it.
// The next payload byte is taken while the current one's last byte is loaded for output.
// Reset (async, active low) clears crc and byte count and sets payload count and flag to 1.
// status_frame_builder_crc8_core: frames payload bytes with header, length, flag and crc-8
// depends on sfb_pkg
module status_frame_builder_crc8_core
  import sfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  // payload input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] payload_byte_i,
  // frame output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o
);

  // configuration registers
  logic [7:0] payload_count_q;
  logic [7:0] flag_byte_q;

  // frame position tracking at the input side
  logic [7:0] cnt_q, cnt_d;

  // job register holding one accepted payload byte and its frame role
  logic       job_valid_q, job_valid_d;
  logic [7:0] job_pb_q;
  logic       job_end_q;
  logic [7:0] job_len_q;
  logic [7:0] job_flag_q;
  logic [2:0] job_pos_q, job_pos_d;

  // running crc and output register
  logic [7:0] crc_q, crc_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_end_q;

  logic       in_accept;
  logic       out_load;
  logic       job_last;
  logic [2:0] last_pos;
  logic [7:0] count_eff;
  logic [7:0] cnt_next;
  logic       in_start;
  logic       in_end;
  logic [7:0] sel_byte;
  logic [7:0] crc_base;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_count_q <= 8'd1;
      flag_byte_q     <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAYLOAD_COUNT: payload_count_q <= cfg_wdata_i;
        REG_FLAG_BYTE:     flag_byte_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // output register loads whenever it is empty or being drained
  assign out_load = job_valid_q && (!out_valid_q || out_ready_i);
  assign last_pos = job_end_q ? POS_CRC : POS_PAYLOAD;
  assign job_last = out_load && (job_pos_q == last_pos);

  // input side handshake
  assign in_ready_o = !job_valid_q || job_last;
  assign in_accept  = in_valid_i && in_ready_o;

  // frame start and end decision for the incoming byte
  always_comb begin
    count_eff = (payload_count_q == 8'd0) ? 8'd1 : payload_count_q;
    in_start  = (cnt_q == 8'd0);
    cnt_next  = (cnt_q < CNT_MAX) ? cnt_q + 8'd1 : cnt_q;
    in_end    = (cnt_next >= count_eff);
    cnt_d     = cnt_q;
    if (in_accept) begin
      cnt_d = in_end ? 8'd0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 8'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // job register next state
  always_comb begin
    job_valid_d = job_valid_q;
    job_pos_d   = job_pos_q;
    if (out_load) begin
      job_pos_d = job_pos_q + 3'd1;
    end
    if (job_last) begin
      job_valid_d = 1'b0;
    end
    if (in_accept) begin
      job_valid_d = 1'b1;
      job_pos_d   = in_start ? POS_HDR0 : POS_PAYLOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      job_pos_q   <= POS_HDR0;
    end else begin
      job_valid_q <= job_valid_d;
      job_pos_q   <= job_pos_d;
    end
  end

  // job payload, captured with the transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      job_pb_q   <= payload_byte_i;
      job_end_q  <= in_end;
      job_len_q  <= count_eff + LEN_OVERHEAD;
      job_flag_q <= flag_byte_q;
    end
  end

  // pick the byte for the current position
  always_comb begin
    case (job_pos_q)
      POS_HDR0:    sel_byte = HDR_B0;
      POS_HDR1:    sel_byte = HDR_B1;
      POS_HDR2:    sel_byte = HDR_B2;
      POS_LEN:     sel_byte = job_len_q;
      POS_FLAG:    sel_byte = job_flag_q;
      POS_PAYLOAD: sel_byte = job_pb_q;
      POS_CRC:     sel_byte = crc_q;
      default:     sel_byte = 8'h00;
    endcase
  end

  // crc runs over each byte but the crc byte itself as it enters the output register
  always_comb begin
    crc_base    = (job_pos_q == POS_HDR0) ? CRC_INIT : crc_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      if (job_pos_q == POS_CRC) begin
        crc_d = CRC_INIT;
      end else begin
        crc_d = crc8_update(crc_base, sel_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= sel_byte;
      out_end_q  <= (job_pos_q == POS_CRC);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign frame_end_o  = out_end_q;

endmodule

// ===== dv/tb.sv =====
// tb: self-checking bench for status_frame_builder_crc8_core
// holds a frame-byte predictor class and the driving tasks; depends on sfb_pkg and the core
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfb_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 8;

  // one predicted byte of the outgoing frame
  typedef struct packed {
    logic [7:0] data;
    logic       closes;
  } frame_entry_t;

  // frame predictor and result checker
  class frame_tracker;
    logic [7:0]   count_reg;
    logic [7:0]   flag_reg;
    logic [7:0]   crc_acc;
    logic [7:0]   bytes_in_frame;
    frame_entry_t expected_bytes[$];
    int           mismatches;
    int           bytes_checked;
    int           frames_closed;

    function new();
      count_reg      = 8'd1;
      flag_reg       = 8'd1;
      crc_acc        = CRC_INIT;
      bytes_in_frame = 8'd0;
      mismatches     = 0;
      bytes_checked  = 0;
      frames_closed  = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] value);
      if (idx == REG_PAYLOAD_COUNT) begin
        count_reg = value;
      end else begin
        flag_reg = value;
      end
    endfunction

    // bit-serial form of the reflected crc, data lsb first
    function logic [7:0] crc_next(logic [7:0] crc, logic [7:0] data);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ data[i];
        r  = r >> 1;
        if (fb) begin
          r = r ^ CRC_POLY_REFL;
        end
      end
      return r;
    endfunction

    function void add_byte(logic [7:0] b);
      expected_bytes.push_back('{data: b, closes: 1'b0});
      crc_acc = crc_next(crc_acc, b);
    endfunction

    // expected frame bytes released by one accepted payload byte
    function void note_payload(logic [7:0] pb);
      logic [7:0] eff_count;
      eff_count = (count_reg == 8'd0) ? 8'd1 : count_reg;
      if (bytes_in_frame == 8'd0) begin
        crc_acc = CRC_INIT;
        add_byte(HDR_B0);
        add_byte(HDR_B1);
        add_byte(HDR_B2);
        add_byte(eff_count + LEN_OVERHEAD);
        add_byte(flag_reg);
      end
      add_byte(pb);
      if (bytes_in_frame != CNT_MAX) begin
        bytes_in_frame = bytes_in_frame + 8'd1;
      end
      // count reached or already passed: crc closes the frame
      if (bytes_in_frame >= eff_count) begin
        expected_bytes.push_back('{data: crc_acc, closes: 1'b1});
        crc_acc        = CRC_INIT;
        bytes_in_frame = 8'd0;
      end
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH: %s", msg);
      end
    endfunction

    function void check_frame_byte(logic [7:0] b, logic e);
      frame_entry_t want;
      bytes_checked++;
      if (e) begin
        frames_closed++;
      end
      if (expected_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected frame byte %h end %b", b, e));
      end else begin
        want = expected_bytes.pop_front();
        if (b !== want.data) begin
          note_mismatch($sformatf("frame_byte expected %h actual %h", want.data, b));
        end
        if (e !== want.closes) begin
          note_mismatch($sformatf("frame_end expected %b actual %b (byte %h)",
                                  want.closes, e, b));
        end
      end
    endfunction

    function void report_leftover();
      if (expected_bytes.size() != 0) begin
        note_mismatch($sformatf("%0d expected frame bytes never arrived",
                                expected_bytes.size()));
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic       cfg_idx_i      = 1'b0;
  logic [7:0] cfg_wdata_i    = 8'h00;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] payload_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] frame_byte_o;
  logic       frame_end_o;

  frame_tracker sb;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic rx_hold_req  = 1'b0;
  int   quiet_cycles = 0;
  int   items_sent   = 0;
  int   reg_writes   = 0;

  status_frame_builder_crc8_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .payload_byte_i (payload_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_byte_o   (frame_byte_o),
    .frame_end_o    (frame_end_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= rx_stall_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_frame_byte(frame_byte_o, frame_end_o);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one payload byte after a random gap, return at its transaction
  task automatic send_payload(input logic [7:0] value);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    payload_byte_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_payload(value);
    items_sent++;
  endtask

  // stop offering and wait for every expected frame byte
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // write both registers, block idle
  task automatic set_config(input logic [7:0] count, input logic [7:0] flag);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_PAYLOAD_COUNT;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_idx_i   <= REG_FLAG_BYTE;
    cfg_wdata_i <= flag;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(REG_PAYLOAD_COUNT, count);
    sb.write_reg(REG_FLAG_BYTE, flag);
    reg_writes += 2;
  endtask

  // mostly short frames, sometimes zero or a large count
  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) begin
      return 8'd0;
    end
    if (r == 9) begin
      return 8'($urandom_range(255, 200));
    end
    return 8'($urandom_range(6, 1));
  endfunction

  // stimulus
  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one byte per frame, payload extremes
    send_payload(8'h00);
    send_payload(8'hFF);

    // zero count acts as one, flag zero
    wait_drained();
    set_config(8'd0, 8'h00);
    send_payload(8'hA5);
    send_payload(8'h5A);

    // count 255: length byte wraps; count lowered mid-frame closes it
    wait_drained();
    set_config(8'd255, 8'hFF);
    send_payload(8'h80);
    wait_drained();
    set_config(8'd1, 8'h11);
    send_payload(8'h01);

    // count 249, length byte still below wrap, then lowered to exactly the bytes sent
    wait_drained();
    set_config(8'd249, 8'h80);
    send_payload(8'h7F);
    send_payload(8'hFE);
    wait_drained();
    set_config(8'd3, 8'h80);
    send_payload(8'h55);

    // plain multi-byte frame
    wait_drained();
    set_config(8'd4, 8'h55);
    send_payload(8'h01);
    send_payload(8'h80);
    send_payload(8'hFF);
    send_payload(8'h00);

    // count above range: length byte wraps to zero
    wait_drained();
    set_config(8'd252, 8'hAA);
    send_payload(8'h3C);
    wait_drained();
    set_config(8'd2, 8'hAA);
    send_payload(8'hC3);

    // long output hold-off while input keeps coming
    wait_drained();
    set_config(8'd3, 8'h3C);
    rx_hold_req = 1'b1;
    repeat (15) send_payload(8'($urandom_range(255, 0)));

    // random frames under each idle mix
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 74;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 74;
        end
        default: begin
          tx_idle_pct  = 38;
          rx_stall_pct = 38;
        end
      endcase
      repeat (4) begin
        wait_drained();
        set_config(pick_count(), 8'($urandom_range(255, 0)));
        repeat ($urandom_range(7, 3)) send_payload(8'($urandom_range(255, 0)));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.report_leftover();

    $display("summary: %0d payload bytes, %0d frame bytes checked, %0d frames closed,",
             items_sent, sb.bytes_checked, sb.frames_closed);
    $display("summary: %0d reg writes; counts 0..255 incl. mid-frame changes, idle mixes,",
             reg_writes);
    $display("summary: long output hold-off");
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
